// ===== hw/rtl/sbr_pkg.sv =====
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared constants, command codes and types of the stuffed bitstream reader.
// ----------------------------------------------------------------------------
package sbr_pkg;

   localparam int BUF_BYTES_DEF   = 4096;
   localparam int BLOCK_BYTES_DEF = 512;
   localparam int MAX_BITS_DEF    = 16;

   localparam int CMD_W   = 3;
   localparam int ADDR_W  = 12;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 5;
   localparam int SKIP_W  = 3;
   localparam int VALUE_W = 16;

   localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'hFF;
   localparam logic [BYTE_W-1:0] STUFF_BYTE  = 8'h00;

   localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SKIP   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CACHE  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RECORD = 3'd5;
   localparam logic [CMD_W-1:0] CMD_BACK   = 3'd6;

   // status of one bit-unit step
   typedef struct packed {
      logic stuffed;   // byte was a stuffed zero and got dropped
      logic finished;  // no bits left to take
   } step_flags_type;

endpackage

// ===== hw/rtl/sbr_byte_store.sv =====
// ----------------------------------------------------------------------------
// sbr_byte_store
// Simple dual-port byte buffer: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sbr_byte_store import sbr_pkg::*; #(
   parameter int DEPTH = BUF_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [BYTE_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [BYTE_W-1:0]        rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sbr_bit_unit.sv =====
// ----------------------------------------------------------------------------
// sbr_bit_unit
// One step of the bit walk: drops a stuffed zero or takes bits from one byte,
// advances the pointer and applies a pending block skip.
// ----------------------------------------------------------------------------
module sbr_bit_unit import sbr_pkg::*; #(
   parameter int BUF_BYTES   = BUF_BYTES_DEF,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  logic [BYTE_W-1:0]            byte_in,
   input  logic [$clog2(BUF_BYTES)-1:0] ptr,
   input  logic [2:0]                   pos,
   input  logic [BYTE_W-1:0]            last,
   input  logic [SKIP_W-1:0]            pend,
   input  logic [COUNT_W-1:0]           need,
   input  logic [VALUE_W-1:0]           acc,
   output logic [$clog2(BUF_BYTES)-1:0] ptr_next,
   output logic [2:0]                   pos_next,
   output logic [BYTE_W-1:0]            last_next,
   output logic [SKIP_W-1:0]            pend_next,
   output logic [COUNT_W-1:0]           need_next,
   output logic [VALUE_W-1:0]           acc_next,
   output step_flags_type               flags
);

   localparam int PTR_W = $clog2(BUF_BYTES);
   localparam int BLK_W = $clog2(BLOCK_BYTES);
   localparam int CHK_W = (BLK_W < PTR_W) ? BLK_W : PTR_W;
   localparam int WIDE_W = PTR_W + SKIP_W;

   logic [PTR_W-1:0]  ptr_inc;
   logic [WIDE_W-1:0] skip_wide;
   logic [PTR_W-1:0]  ptr_adv;
   logic              skip_hit;
   logic [3:0]        avail;
   logic [3:0]        take;
   logic [3:0]        shift;
   logic [8:0]        mask;
   logic [BYTE_W-1:0] bits;
   logic [3:0]        pos_sum;
   logic              stuffed;

   // pointer advance with wrap, then the block skip on a boundary
   always_comb begin
      ptr_inc   = (ptr == PTR_W'(BUF_BYTES - 1)) ? '0 : ptr + 1'b1;
      skip_wide = WIDE_W'(pend) << BLK_W;
      skip_hit  = (pend != '0) && (ptr_inc[CHK_W-1:0] == '0);
      ptr_adv   = skip_hit ? ptr_inc + skip_wide[PTR_W-1:0] : ptr_inc;
   end

   always_comb begin
      stuffed = (last == MARKER_BYTE) && (byte_in == STUFF_BYTE);
      avail   = 4'd8 - {1'b0, pos};
      take    = ({1'b0, need} < {1'b0, avail}) ? need[3:0] : avail;
      shift   = avail - take;
      mask    = (9'd1 << take) - 9'd1;
      bits    = (byte_in >> shift) & mask[BYTE_W-1:0];
      pos_sum = {1'b0, pos} + take;

      ptr_next  = ptr;
      pos_next  = pos;
      last_next = last;
      pend_next = pend;
      need_next = need;
      acc_next  = acc;
      if (stuffed) begin
         ptr_next  = ptr_adv;
         pos_next  = '0;
         last_next = STUFF_BYTE;
         if (skip_hit) begin
            pend_next = '0;
         end
      end else begin
         acc_next  = VALUE_W'({acc, 8'h00} >> (4'd8 - take)) | VALUE_W'(bits);
         need_next = need - COUNT_W'(take);
         pos_next  = pos_sum[2:0];
         if (pos_sum[3]) begin
            last_next = byte_in;
            ptr_next  = ptr_adv;
            pos_next  = '0;
            if (skip_hit) begin
               pend_next = '0;
            end
         end
      end
      flags.stuffed  = stuffed;
      flags.finished = (need_next == '0);
   end

endmodule

// ===== hw/rtl/stuffed_bitstream_reader_top.sv =====
// ----------------------------------------------------------------------------
// stuffed_bitstream_reader_top
// Bit reader over a loadable byte buffer with JPEG byte unstuffing,
// block skipping and save/commit/rewind of the read position.
// ----------------------------------------------------------------------------
// One command beat in, one result beat out. Load, set skip, cache, record,
// back, out-of-range or zero-length reads and the unused code pass from
// accept through the done state into the output register. Read and peek
// walk the buffer byte by byte through the byte store, each byte a fetch
// with registered read data and then a step in the shared bit unit. The
// bytes touched include dropped stuffed zeros: a 16-bit read spans two or
// three data bytes, and dropped stuffed zeros add up to three more bytes.
// The block takes no new command while one is in work; a finished result
// sits in the output register, so a new command is accepted while the
// result still waits. BUF_BYTES and BLOCK_BYTES are powers of two; MAX_BITS
// is 8 to 32, and only the low 16 bits of a read come out. The byte store
// has no reset: read only addresses that were loaded.
// ----------------------------------------------------------------------------
module stuffed_bitstream_reader_top import sbr_pkg::*; #(
   parameter int BUF_BYTES   = BUF_BYTES_DEF,
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
   parameter int MAX_BITS    = MAX_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [ADDR_W-1:0]  req_addr,
   input  logic [BYTE_W-1:0]  req_data,
   input  logic [COUNT_W-1:0] req_bit_count,
   input  logic [SKIP_W-1:0]  req_skip_blocks,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_value,
   output logic               rsp_skipped
);

   localparam int PTR_W = $clog2(BUF_BYTES);
   localparam logic [5:0] MAX_BITS_C = 6'(MAX_BITS);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;  // byte read issued
   localparam logic [1:0] ST_STEP  = 2'd2;  // byte in bit unit
   localparam logic [1:0] ST_DONE  = 2'd3;  // result waits for output slot

   logic [1:0]         state_ff, state_in;

   // committed reader state
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [2:0]         pos_ff, pos_in;
   logic [BYTE_W-1:0]  last_ff, last_in;
   logic [SKIP_W-1:0]  pend_ff, pend_in;
   logic [PTR_W-1:0]   cptr_ff, cptr_in;
   logic [2:0]         cbit_ff, cbit_in;
   logic [PTR_W-1:0]   rptr_ff, rptr_in;
   logic [2:0]         rbit_ff, rbit_in;
   logic               skip_ff, skip_in;

   // working copy during a read or peek walk
   logic [PTR_W-1:0]   w_ptr_ff, w_ptr_in;
   logic [2:0]         w_pos_ff, w_pos_in;
   logic [BYTE_W-1:0]  w_last_ff, w_last_in;
   logic [SKIP_W-1:0]  w_pend_ff, w_pend_in;
   logic [COUNT_W-1:0] need_ff, need_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               peek_ff, peek_in;

   // result and output register
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_skipped_ff, rsp_skipped_in;

   logic               req_accept;
   logic               out_free;
   logic               wr_en;
   logic               rd_en;
   logic [BYTE_W-1:0]  rd_data;

   logic [PTR_W-1:0]   u_ptr;
   logic [2:0]         u_pos;
   logic [BYTE_W-1:0]  u_last;
   logic [SKIP_W-1:0]  u_pend;
   logic [COUNT_W-1:0] u_need;
   logic [VALUE_W-1:0] u_acc;
   step_flags_type     u_flags;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign wr_en = req_accept && (req_cmd == CMD_LOAD);
   assign rd_en = (state_ff == ST_FETCH);

   sbr_byte_store #(
      .DEPTH (BUF_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (PTR_W'(req_addr)),
      .wr_data (req_data),
      .rd_en   (rd_en),
      .rd_addr (w_ptr_ff),
      .rd_data (rd_data)
   );

   sbr_bit_unit #(
      .BUF_BYTES   (BUF_BYTES),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_bits (
      .byte_in   (rd_data),
      .ptr       (w_ptr_ff),
      .pos       (w_pos_ff),
      .last      (w_last_ff),
      .pend      (w_pend_ff),
      .need      (need_ff),
      .acc       (acc_ff),
      .ptr_next  (u_ptr),
      .pos_next  (u_pos),
      .last_next (u_last),
      .pend_next (u_pend),
      .need_next (u_need),
      .acc_next  (u_acc),
      .flags     (u_flags)
   );

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      pend_in      = pend_ff;
      cptr_in      = cptr_ff;
      cbit_in      = cbit_ff;
      rptr_in      = rptr_ff;
      rbit_in      = rbit_ff;
      skip_in      = skip_ff;
      w_ptr_in     = w_ptr_ff;
      w_pos_in     = w_pos_ff;
      w_last_in    = w_last_ff;
      w_pend_in    = w_pend_ff;
      need_in      = need_ff;
      acc_in       = acc_ff;
      peek_in      = peek_ff;
      res_value_in = res_value_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               res_value_in = '0;
               state_in     = ST_DONE;
               case (req_cmd)
                  CMD_READ, CMD_PEEK: begin
                     // zero-length and too-long reads change nothing
                     if (req_bit_count != '0 && {1'b0, req_bit_count} <= MAX_BITS_C) begin
                        w_ptr_in  = ptr_ff;
                        w_pos_in  = pos_ff;
                        w_last_in = last_ff;
                        w_pend_in = pend_ff;
                        need_in   = req_bit_count;
                        acc_in    = '0;
                        peek_in   = (req_cmd == CMD_PEEK);
                        state_in  = ST_FETCH;
                     end
                  end
                  CMD_SKIP: begin
                     pend_in = req_skip_blocks;
                  end
                  CMD_CACHE: begin
                     cptr_in = ptr_ff;
                     cbit_in = pos_ff;
                  end
                  CMD_RECORD: begin
                     // commit only on a new byte position
                     if (rptr_ff != cptr_ff) begin
                        skip_in = 1'b0;
                        rptr_in = cptr_ff;
                        rbit_in = cbit_ff;
                     end
                  end
                  CMD_BACK: begin
                     skip_in = 1'b1;
                     ptr_in  = rptr_ff;
                     pos_in  = rbit_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            w_ptr_in  = u_ptr;
            w_pos_in  = u_pos;
            w_last_in = u_last;
            w_pend_in = u_pend;
            need_in   = u_need;
            acc_in    = u_acc;
            if (u_flags.finished) begin
               res_value_in = u_acc;
               state_in     = ST_DONE;
               if (!peek_ff) begin
                  ptr_in  = u_ptr;
                  pos_in  = u_pos;
                  last_in = u_last;
                  pend_in = u_pend;
               end
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: loaded from the done state, cleared when taken
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_value_in   = rsp_value_ff;
      rsp_skipped_in = rsp_skipped_ff;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_value_in   = res_value_ff;
         rsp_skipped_in = skip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         pos_ff       <= '0;
         last_ff      <= '0;
         pend_ff      <= '0;
         cptr_ff      <= '0;
         cbit_ff      <= '0;
         rptr_ff      <= '0;
         rbit_ff      <= '0;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         pos_ff       <= pos_in;
         last_ff      <= last_in;
         pend_ff      <= pend_in;
         cptr_ff      <= cptr_in;
         cbit_ff      <= cbit_in;
         rptr_ff      <= rptr_in;
         rbit_ff      <= rbit_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ptr_ff       <= w_ptr_in;
      w_pos_ff       <= w_pos_in;
      w_last_ff      <= w_last_in;
      w_pend_ff      <= w_pend_in;
      need_ff        <= need_in;
      acc_ff         <= acc_in;
      peek_ff        <= peek_in;
      res_value_ff   <= res_value_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_skipped_ff <= rsp_skipped_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_skipped = rsp_skipped_ff;

   // byte data in the bit unit always comes from the fetch just before
   a_step_after_fetch: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP |-> $past(state_ff) == ST_FETCH)
      else $error("bit step without a preceding byte fetch");

   // a walk in progress always has bits left to take
   a_need_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH || state_ff == ST_STEP) |-> need_ff != '0)
      else $error("byte walk running with nothing left to read");

   // a peek step never moves the committed pointer
   a_peek_keeps_ptr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && peek_ff) |=> ptr_ff == $past(ptr_ff))
      else $error("peek changed the read pointer");

   // a dropped stuffed zero leaves a zero as the last consumed byte
   a_stuff_clears_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP && u_flags.stuffed) |=> w_last_ff == STUFF_BYTE)
      else $error("stuffed byte not recorded as last consumed");

endmodule
